// ----- hw/rtl/kerq_pkg.sv -----
// ----------------------------------------------------------------------------
// kerq_pkg: shared types and constants of the key event ring queue
// Transaction payloads, action and register codes, state encoding.
// ----------------------------------------------------------------------------
package kerq_pkg;

	localparam int KERQ_DEPTH      = 256;
	localparam int KERQ_ENTRY_BITS = 16;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_CODE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIDDLE_CODE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_CODE  = 2'd2;

	localparam logic [7:0] LEFT_CODE_RST   = 8'd1;
	localparam logic [7:0] MIDDLE_CODE_RST = 8'd4;
	localparam logic [7:0] RIGHT_CODE_RST  = 8'd2;

	// mouse button numbers
	localparam logic [2:0] BTN_LEFT   = 3'd1;
	localparam logic [2:0] BTN_MIDDLE = 3'd2;
	localparam logic [2:0] BTN_RIGHT  = 3'd3;

	typedef enum logic [1:0] {
		ACT_KEY   = 2'd0,
		ACT_CLICK = 2'd1,
		ACT_POP   = 2'd2,
		ACT_CLEAR = 2'd3
	} kerq_action_t;

	typedef struct packed {
		kerq_action_t action;
		logic [7:0]   scancode;
		logic [2:0]   button;
		logic         release_req;
		logic         shift_held;
		logic         ctrl_held;
		logic         alt_held;
		logic [15:0]  pos_x;
		logic [15:0]  pos_y;
	} kerq_req_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] key_word;
		logic [15:0] click_x;
		logic [15:0] click_y;
		logic        is_click;
		logic        pending;
		logic [15:0] head_word;
	} kerq_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_KEY,
		ST_PUSH_X,
		ST_PUSH_Y,
		ST_POP_RD,
		ST_POP_CHK,
		ST_POP_X,
		ST_POP_Y,
		ST_HEAD_RD,
		ST_RESULT
	} kerq_state_t;

endpackage

// ----- hw/rtl/kerq_if.sv -----
// ----------------------------------------------------------------------------
// kerq_if: valid/ready channels of the key event ring queue
// One interface for the request side, one for the response side.
// ----------------------------------------------------------------------------
interface kerq_req_if;
	import kerq_pkg::*;

	logic      valid;
	logic      ready;
	kerq_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kerq_rsp_if;
	import kerq_pkg::*;

	logic      valid;
	logic      ready;
	kerq_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/key_event_ring_queue.sv -----
// ----------------------------------------------------------------------------
// key_event_ring_queue: ring queue of key events and mouse clicks
// Key words and click triples live in one single-port synchronous memory;
// a small sequencer pushes, pops and reads back the head word.
// ----------------------------------------------------------------------------
// channel  dir  kind          contents
// req      in   valid/ready   action, scancode, button, modifiers, x, y
// rsp      out  valid/ready   accepted, key_word, click x/y, is_click,
//                             pending, head_word
// cfg      in   write only    cfg_we, cfg_index, cfg_data (button codes)
//
// transaction steps: key push writes the key word, click push then writes x
//   and y, pop reads the head word and, for a click, x and y; every memory
//   access uses the single port; all but an empty pop end in a head read-back
// reset clears indexes and held coordinates and loads default button codes; the memory
//   content is not cleared, so no clearing pass is needed
// req is taken only in idle; a response waiting in the output register
//   does not block the next request, only the result load of that request
// ----------------------------------------------------------------------------
module key_event_ring_queue #(
	parameter int QUEUE_DEPTH = kerq_pkg::KERQ_DEPTH,
	parameter int ENTRY_BITS  = kerq_pkg::KERQ_ENTRY_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	kerq_req_if.sink                           req,
	kerq_rsp_if.source                         rsp,
	input  logic                               cfg_we,
	input  logic [kerq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [kerq_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import kerq_pkg::*;

	localparam int IDX_BITS = $clog2(QUEUE_DEPTH);

	// index step with wrap, valid for any depth of at least four
	function automatic logic [IDX_BITS-1:0] wrap_add(input logic [IDX_BITS-1:0] idx,
			input logic [1:0] step);
		logic [IDX_BITS:0] sum;
		sum = {1'b0, idx} + (IDX_BITS+1)'(step);
		if (sum >= (IDX_BITS+1)'(QUEUE_DEPTH)) begin
			sum = sum - (IDX_BITS+1)'(QUEUE_DEPTH);
		end
		return sum[IDX_BITS-1:0];
	endfunction

	// state and registers
	kerq_state_t state_q, state_d;

	kerq_req_t               cmd_q;           // transaction under work
	logic [IDX_BITS-1:0]     rd_q, wr_q;      // queue head and tail
	logic [15:0]             held_x_q, held_y_q;
	logic                    acc_q, is_click_q;
	logic [15:0]             key_word_q;
	logic [7:0]              left_code_q, middle_code_q, right_code_q;
	logic                    out_valid_q;
	kerq_rsp_t               out_data_q;

	// queue memory, one port, registered read data
	logic [ENTRY_BITS-1:0]   mem_q [QUEUE_DEPTH];
	logic [ENTRY_BITS-1:0]   rd_data_q;
	logic                    mem_we, mem_re;
	logic [IDX_BITS-1:0]     mem_addr;
	logic [ENTRY_BITS-1:0]   mem_wdata;

	// key word built from the transaction under work
	logic [7:0]              btn_code;
	logic                    btn_known;
	logic [7:0]              code;
	logic                    code_is_mouse;
	logic [11:0]             word12;
	logic                    word_nz;
	logic [IDX_BITS-1:0]     wr_next;
	logic                    full;
	logic                    head_is_mouse;
	logic                    pending;
	logic                    rsp_load;

	always_comb begin
		case (cmd_q.button)
			BTN_LEFT: begin
				btn_code  = left_code_q;
				btn_known = 1'b1;
			end
			BTN_MIDDLE: begin
				btn_code  = middle_code_q;
				btn_known = 1'b1;
			end
			BTN_RIGHT: begin
				btn_code  = right_code_q;
				btn_known = 1'b1;
			end
			default: begin
				btn_code  = 8'd0;
				btn_known = 1'b0;
			end
		endcase
	end

	assign code          = (cmd_q.action == ACT_KEY) ? cmd_q.scancode : btn_code;
	assign code_is_mouse = (code == left_code_q) || (code == middle_code_q) ||
		(code == right_code_q);
	// release at bit 11, alt 10, ctrl 9, shift 8; modifiers dropped on mouse codes
	assign word12  = {cmd_q.release_req,
		code_is_mouse ? 3'b000 : {cmd_q.alt_held, cmd_q.ctrl_held, cmd_q.shift_held},
		code};
	assign word_nz = |word12;

	// one slot stays free so that full and empty differ
	assign wr_next = wrap_add(wr_q, 2'd1);
	assign full    = (wr_next == rd_q);

	assign head_is_mouse = (rd_data_q[7:0] == left_code_q) ||
		(rd_data_q[7:0] == middle_code_q) || (rd_data_q[7:0] == right_code_q);

	assign pending  = (rd_q != wr_q);
	assign rsp_load = (state_q == ST_RESULT) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	// sequencer: next state and memory port control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = wr_q;
		mem_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.data.action)
						ACT_KEY:   state_d = ST_PUSH_KEY;
						ACT_CLICK: state_d = ST_PUSH_KEY;
						ACT_POP:   state_d = ST_POP_RD;
						default:   state_d = ST_HEAD_RD;
					endcase
				end
			end
			ST_PUSH_KEY: begin
				// unknown buttons push nothing at all
				if (cmd_q.action == ACT_CLICK && !btn_known) begin
					state_d = ST_HEAD_RD;
				end else begin
					mem_wdata = ENTRY_BITS'(word12);
					mem_we    = word_nz && !full;
					state_d   = (cmd_q.action == ACT_CLICK) ? ST_PUSH_X : ST_HEAD_RD;
				end
			end
			ST_PUSH_X: begin
				mem_wdata = ENTRY_BITS'(cmd_q.pos_x);
				mem_we    = !full;
				state_d   = ST_PUSH_Y;
			end
			ST_PUSH_Y: begin
				mem_wdata = ENTRY_BITS'(cmd_q.pos_y);
				mem_we    = !full;
				state_d   = ST_HEAD_RD;
			end
			ST_POP_RD: begin
				if (!pending) begin
					state_d = ST_RESULT;
				end else begin
					mem_re   = 1'b1;
					mem_addr = rd_q;
					state_d  = ST_POP_CHK;
				end
			end
			ST_POP_CHK: begin
				if (head_is_mouse) begin
					mem_re   = 1'b1;
					mem_addr = wrap_add(rd_q, 2'd1);
					state_d  = ST_POP_X;
				end else begin
					state_d = ST_HEAD_RD;
				end
			end
			ST_POP_X: begin
				mem_re   = 1'b1;
				mem_addr = wrap_add(rd_q, 2'd2);
				state_d  = ST_POP_Y;
			end
			ST_POP_Y: begin
				state_d = ST_HEAD_RD;
			end
			ST_HEAD_RD: begin
				mem_re   = pending;
				mem_addr = rd_q;
				state_d  = ST_RESULT;
			end
			ST_RESULT: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// queue memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_addr];
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.data;
		end
	end

	// queue indexes, held coordinates, per-transaction flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q       <= '0;
			wr_q       <= '0;
			held_x_q   <= '0;
			held_y_q   <= '0;
			acc_q      <= 1'b0;
			is_click_q <= 1'b0;
			key_word_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						acc_q      <= 1'b0;
						is_click_q <= 1'b0;
						key_word_q <= '0;
						if (req.data.action == ACT_CLEAR) begin
							rd_q <= wr_q;
						end
					end
				end
				ST_PUSH_KEY: begin
					acc_q <= mem_we;
					if (mem_we) begin
						wr_q <= wr_next;
					end
				end
				ST_PUSH_X, ST_PUSH_Y: begin
					if (mem_we) begin
						wr_q <= wr_next;
					end
				end
				ST_POP_CHK: begin
					acc_q      <= 1'b1;
					key_word_q <= 16'(rd_data_q);
					if (head_is_mouse) begin
						is_click_q <= 1'b1;
					end else begin
						rd_q <= wrap_add(rd_q, 2'd1);
					end
				end
				ST_POP_X: begin
					held_x_q <= 16'(rd_data_q);
				end
				ST_POP_Y: begin
					held_y_q <= 16'(rd_data_q);
					rd_q     <= wrap_add(rd_q, 2'd3);
				end
				default: begin
				end
			endcase
		end
	end

	// button code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_code_q   <= LEFT_CODE_RST;
			middle_code_q <= MIDDLE_CODE_RST;
			right_code_q  <= RIGHT_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_CODE:   left_code_q   <= cfg_data;
				REG_MIDDLE_CODE: middle_code_q <= cfg_data;
				REG_RIGHT_CODE:  right_code_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_data_q.accepted  <= acc_q;
			out_data_q.key_word  <= key_word_q;
			out_data_q.click_x   <= held_x_q;
			out_data_q.click_y   <= held_y_q;
			out_data_q.is_click  <= is_click_q;
			out_data_q.pending   <= pending;
			out_data_q.head_word <= pending ? 16'(rd_data_q) : 16'd0;
		end
	end

endmodule

// ----- hw/rtl/kerq_checker.sv -----
// ----------------------------------------------------------------------------
// kerq_checker: port-level checks of the key event ring queue
// Watches the request and response channels; bound into key_event_ring_queue.
// ----------------------------------------------------------------------------
module kerq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input kerq_pkg::kerq_rsp_t rsp_data
);
	import kerq_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// one transaction at a time: ready drops after an accept
	a_req_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a refused transaction carries no popped word
	a_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.accepted |->
			rsp_data.key_word == 16'd0 && !rsp_data.is_click)
		else $error("popped word without accept");

	// empty queue shows a zero head
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.pending |-> rsp_data.head_word == 16'd0)
		else $error("head word on empty queue");

endmodule

bind key_event_ring_queue kerq_checker u_kerq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
